[design/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point-in-polygon classifier
// Command codes, field widths and the record that moves along the edge chain.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int COORD_W          = 16;
  localparam int CMD_W            = 2;
  localparam int COUNT_W          = 6;
  localparam int MIN_POLY         = 3;
  localparam int MAX_VERTICES_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

  // one test point travelling down the chain with its running parity
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      parity;
  } chain_t;

endpackage

[design/pip_edge_cell.sv]
// ----------------------------------------------------------------------------
// pip_edge_cell: one polygon edge of the classifier chain
// Holds both endpoints of one edge, forms the exact crossing products for the
// point passing by, and toggles the parity when an enabled edge crosses its ray.
// ----------------------------------------------------------------------------
module pip_edge_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               load_i,
  input  logic                               load_j,
  input  logic signed [pip_pkg::COORD_W-1:0] wi_x,
  input  logic signed [pip_pkg::COORD_W-1:0] wi_y,
  input  logic signed [pip_pkg::COORD_W-1:0] wj_x,
  input  logic signed [pip_pkg::COORD_W-1:0] wj_y,
  input  logic                               edge_en,
  input  pip_pkg::chain_t                    chain_in,
  output pip_pkg::chain_t                    chain_out
);
  import pip_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;

  logic signed [COORD_W-1:0] xi, yi, xj, yj;

  logic signed [DIFF_W-1:0] dy, da, db, dc;
  logic signed [PROD_W-1:0] lhs_c, rhs_c;
  logic                     straddle_c;

  chain_t                   st;
  logic signed [PROD_W-1:0] lhs, rhs;
  logic                     straddle, dypos;
  logic                     left;

  // edge endpoints, written only while no test is in flight
  always_ff @(posedge clk) begin
    if (load_i) begin
      xi <= wi_x;
      yi <= wi_y;
    end
    if (load_j) begin
      xj <= wj_x;
      yj <= wj_y;
    end
  end

  always_comb begin
    dy         = DIFF_W'(yj) - DIFF_W'(yi);
    da         = DIFF_W'(chain_in.px) - DIFF_W'(xi);
    db         = DIFF_W'(xj) - DIFF_W'(xi);
    dc         = DIFF_W'(chain_in.py) - DIFF_W'(yi);
    lhs_c      = PROD_W'(da) * PROD_W'(dy);
    rhs_c      = PROD_W'(db) * PROD_W'(dc);
    straddle_c = (yi > chain_in.py) != (yj > chain_in.py);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else if (adv) begin
      st.valid <= chain_in.valid;
    end
    if (adv) begin
      st.px     <= chain_in.px;
      st.py     <= chain_in.py;
      st.parity <= chain_in.parity;
      lhs       <= lhs_c;
      rhs       <= rhs_c;
      straddle  <= straddle_c;
      dypos     <= dy > DIFF_W'(0);
    end
  end

  // sense of the compare flips when the edge runs downward
  assign left = dypos ? (lhs < rhs) : (lhs > rhs);

  always_comb begin
    chain_out        = st;
    chain_out.parity = st.parity ^ (edge_en & straddle & left);
  end

endmodule

[design/point_in_polygon_classifier.sv]
// Point-in-polygon classifier (even-odd ray casting). Vertices are appended one
// per item into a row of MAX_VERTICES edge cells; each cell keeps one edge and
// a test point walks the row one cell per cycle while the output is not held, so
// tests stream at one item per cycle, and each result passes through every cell
// register and then the output register. Clear, append and unused commands
// answer on the next cycle but are taken only once every test ahead of them
// has left the row; a held output stalls the whole row.
// ----------------------------------------------------------------------------
// point_in_polygon_classifier: top level
// Vertex loading, command sequencing, the edge cell row and the output register.
// ----------------------------------------------------------------------------
module point_in_polygon_classifier #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pip_pkg::CMD_W-1:0]          command,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               inside_res,
  output logic [pip_pkg::COUNT_W-1:0]        vertex_count,
  output logic                               table_full
);
  import pip_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] inflight;
  logic signed [COORD_W-1:0] last_x, last_y;

  logic adv, is_test, idle, acc, acc_test, acc_other;
  logic append, room, do_app, poly_ok;

  chain_t chain [0:MAX_VERTICES];

  assign adv       = !out_valid || out_ready;
  assign is_test   = command == CMD_TEST;
  assign idle      = inflight == '0;
  assign in_ready  = adv && (is_test || idle);
  assign acc       = in_valid && in_ready;
  assign acc_test  = acc && is_test;
  assign acc_other = acc && !is_test;
  assign append    = acc_other && (command == CMD_APPEND);
  assign room      = count < CNT_W'(MAX_VERTICES);
  assign do_app    = append && room;
  assign poly_ok   = count >= CNT_W'(MIN_POLY);

  always_comb begin
    count_next = count;
    if (acc_other && (command == CMD_CLEAR)) begin
      count_next = '0;
    end else if (do_app) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      inflight <= '0;
    end else begin
      count    <= count_next;
      inflight <= inflight + CNT_W'(acc_test) - CNT_W'(adv && chain[MAX_VERTICES].valid);
    end
  end

  always_ff @(posedge clk) begin
    if (do_app) begin
      last_x <= coord_x;
      last_y <= coord_y;
    end
  end

  always_comb begin
    chain[0].valid  = acc_test;
    chain[0].px     = coord_x;
    chain[0].py     = coord_y;
    chain[0].parity = 1'b0;
  end

  // cell 0 carries the closing edge from the last vertex back to the first
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic load_here;
    assign load_here = do_app && (count == CNT_W'(k));

    pip_edge_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .load_i    (load_here),
      .load_j    ((k == 0) ? do_app : load_here),
      .wi_x      (coord_x),
      .wi_y      (coord_y),
      .wj_x      ((k == 0) ? coord_x : last_x),
      .wj_y      ((k == 0) ? coord_y : last_y),
      .edge_en   (poly_ok && (count > CNT_W'(k))),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= acc_other || chain[MAX_VERTICES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc_other) begin
        inside_res   <= 1'b0;
        vertex_count <= COUNT_W'(count_next);
        table_full   <= append && !room;
      end else if (chain[MAX_VERTICES].valid) begin
        inside_res   <= chain[MAX_VERTICES].parity;
        vertex_count <= COUNT_W'(count);
        table_full   <= 1'b0;
      end
    end
  end

  // no more tests in flight than the row has cells
  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(MAX_VERTICES))
    else $error("tests in flight exceed row depth");

  // table changes only with the row drained
  a_load_when_idle: assert property (@(posedge clk) disable iff (rst)
    acc_other |-> idle && !chain[MAX_VERTICES].valid)
    else $error("clear or append taken with tests in flight");

  // a refused append only happens on a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> count == CNT_W'(MAX_VERTICES))
    else $error("table_full flagged below capacity");

  // fewer than three vertices never reports inside
  a_inside_poly: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> poly_ok)
    else $error("inside reported for degenerate polygon");

  // vertex count stays put while tests are in flight
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !idle |=> $stable(count))
    else $error("vertex count changed under a test");

endmodule

[tb/sv/pip_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pip_checker: result checker for the point-in-polygon classifier
// Watches both channels, keeps its own vertex table, classifies every accepted
// test by even-odd ray casting and compares each result in order.
// ----------------------------------------------------------------------------
module pip_checker #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [pip_pkg::CMD_W-1:0]          command,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               inside_res,
  input  logic [pip_pkg::COUNT_W-1:0]        vertex_count,
  input  logic                               table_full,
  output int                                 errors,
  output int                                 pending,
  output int                                 inside_seen,
  output int                                 refused_seen
);
  import pip_pkg::*;

  typedef struct {
    logic               hit;
    logic [COUNT_W-1:0] count;
    logic               full;
  } answer_t;

  answer_t                   answer_q[$];
  logic signed [COORD_W-1:0] poly_x[MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y[MAX_VERTICES];
  int                        poly_len;

  initial begin
    errors       = 0;
    pending      = 0;
    inside_seen  = 0;
    refused_seen = 0;
    poly_len     = 0;
  end

  // even-odd crossing count with the exact cross-multiplied comparison
  function automatic logic ray_parity(input logic signed [COORD_W-1:0] px,
                                      input logic signed [COORD_W-1:0] py);
    longint xi, yi, xj, yj, dy, lhs, rhs;
    logic   parity, left;
    int     i, j;
    parity = 1'b0;
    if (poly_len < MIN_POLY) return 1'b0;
    j = poly_len - 1;
    for (i = 0; i < poly_len; i++) begin
      xi = longint'(poly_x[i]);
      yi = longint'(poly_y[i]);
      xj = longint'(poly_x[j]);
      yj = longint'(poly_y[j]);
      if ((yi > longint'(py)) != (yj > longint'(py))) begin
        dy   = yj - yi;
        lhs  = (longint'(px) - xi) * dy;
        rhs  = (xj - xi) * (longint'(py) - yi);
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  function automatic answer_t apply_item(input logic [CMD_W-1:0]          cmd,
                                         input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y);
    answer_t a;
    a.hit  = 1'b0;
    a.full = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        poly_len = 0;
      end
      CMD_APPEND: begin
        if (poly_len < MAX_VERTICES) begin
          poly_x[poly_len] = x;
          poly_y[poly_len] = y;
          poly_len++;
        end else begin
          a.full = 1'b1;
        end
      end
      CMD_TEST: begin
        a.hit = ray_parity(x, y);
      end
      default: ;
    endcase
    a.count = COUNT_W'(poly_len);
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      poly_len = 0;
      answer_q.delete();
    end else begin
      // a result never belongs to the item taken on the same edge
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("result with no item outstanding: inside_res %0b vertex_count %0d table_full %0b",
                 inside_res, vertex_count, table_full);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (inside_res !== want.hit) begin
            $error("inside_res: expected %0b, got %0b", want.hit, inside_res);
            errors++;
          end
          if (vertex_count !== want.count) begin
            $error("vertex_count: expected %0d, got %0d", want.count, vertex_count);
            errors++;
          end
          if (table_full !== want.full) begin
            $error("table_full: expected %0b, got %0b", want.full, table_full);
            errors++;
          end
          if (want.hit) inside_seen++;
          if (want.full) refused_seen++;
        end
      end
      if (in_valid && in_ready) begin
        answer_q.insert(answer_q.size(), apply_item(command, coord_x, coord_y));
      end
    end
    pending = answer_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the point-in-polygon classifier
// Drives directed corner items, then random polygons with aimed test points
// and bursts of stray commands, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import pip_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int ROW_DEPTH    = MAX_VERTICES_DEF + 1;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          command   = CMD_CLEAR;
  logic signed [COORD_W-1:0] coord_x   = '0;
  logic signed [COORD_W-1:0] coord_y   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      inside_res;
  logic [COUNT_W-1:0]        vertex_count;
  logic                      table_full;

  int errors, pending, inside_seen, refused_seen;
  int cycle_count = 0;
  int n_items = 0, n_clear = 0, n_append = 0, n_test = 0, n_unused = 0;
  int send_calm = 0;
  int shape_x[$], shape_y[$];

  always #4 clk = ~clk;

  point_in_polygon_classifier dut (
    .clk, .rst, .in_valid, .in_ready, .command, .coord_x, .coord_y,
    .out_valid, .out_ready, .inside_res, .vertex_count, .table_full
  );

  pip_checker #(.MAX_VERTICES(MAX_VERTICES_DEF)) u_checker (
    .clk, .rst, .in_valid, .in_ready, .command, .coord_x, .coord_y,
    .out_valid, .out_ready, .inside_res, .vertex_count, .table_full,
    .errors, .pending, .inside_seen, .refused_seen
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("** point_in_polygon_classifier: FAILED **");
      $finish;
    end
  end

  // result side: short and long stalls, with calm stretches of steady ready
  initial begin : result_sink
    int stall, calm, r;
    stall = 0;
    calm  = 0;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm--;
        out_ready = 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 2) calm = $urandom_range(50, 300);
        else if (r < 20) stall = $urandom_range(1, 3);
        else if (r < 23) stall = $urandom_range(10, 40);
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) send_calm = $urandom_range(40, 200);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return COORD_W'(v);
  endfunction

  function automatic int near(input int c, input int r);
    return c - r + int'($urandom_range(0, 2 * r));
  endfunction

  function automatic logic signed [COORD_W-1:0] any16();
    return COORD_W'($urandom);
  endfunction

  task automatic push_item(input logic [CMD_W-1:0]          cmd,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    int gap;
    gap = gap_len();
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    coord_x  = x;
    coord_y  = y;
    do @(posedge clk); while (!in_ready);
    n_items++;
    case (cmd)
      CMD_CLEAR:  n_clear++;
      CMD_APPEND: n_append++;
      CMD_TEST:   n_test++;
      default:    n_unused++;
    endcase
  endtask

  task automatic add_vertex(input int x, input int y);
    push_item(CMD_APPEND, clamp16(x), clamp16(y));
    shape_x.insert(shape_x.size(), int'(clamp16(x)));
    shape_y.insert(shape_y.size(), int'(clamp16(y)));
  endtask

  // test point: random, vertex, vertex row, edge midpoint or near the centre
  task automatic probe(input int cx, input int cy, input int rad);
    int s, k, e, px, py;
    s = shape_x.size();
    k = (s > 0) ? $urandom_range(0, s - 1) : 0;
    e = (s > 0) ? (k + 1) % s : 0;
    case ((s == 0) ? 0 : $urandom_range(0, 9))
      0: begin
        px = any16();
        py = any16();
      end
      1: begin
        px = shape_x[k];
        py = shape_y[k];
      end
      2: begin
        px = near(cx, rad);
        py = shape_y[k];
      end
      3: begin
        px = (shape_x[k] + shape_x[e]) >>> 1;
        py = (shape_y[k] + shape_y[e]) >>> 1;
      end
      default: begin
        px = near(cx, rad + rad / 4);
        py = near(cy, rad + rad / 4);
      end
    endcase
    push_item(CMD_TEST, clamp16(px), clamp16(py));
  endtask

  task automatic polygon_round(input int forced_n);
    int n, kind, cx, cy, rad, tests, r, k, x0, y0, x1, y1;
    r = $urandom_range(0, 99);
    if (r < 60) n = $urandom_range(3, 8);
    else if (r < 85) n = $urandom_range(9, 20);
    else if (r < 95) n = $urandom_range(21, MAX_VERTICES_DEF);
    else n = $urandom_range(MAX_VERTICES_DEF + 1, MAX_VERTICES_DEF + 4);
    kind = $urandom_range(0, 3);
    if (forced_n > 0) begin
      n    = forced_n;
      kind = 0;
    end
    case (kind)
      0: begin
        cx  = 0;
        cy  = 0;
        rad = 32767;
      end
      1: begin
        rad = $urandom_range(256, 4096);
        cx  = near(0, 28000);
        cy  = near(0, 28000);
      end
      default: begin
        rad = $urandom_range(4, 64);
        cx  = near(0, 32000);
        cy  = near(0, 32000);
      end
    endcase
    if (forced_n > 0 || $urandom_range(0, 9) != 0) begin
      push_item(CMD_CLEAR, any16(), any16());
      shape_x.delete();
      shape_y.delete();
    end
    if (kind == 3) begin
      // axis-aligned box: points on its vertical edges sit on a crossing
      x0 = near(0, 30000);
      y0 = near(0, 30000);
      x1 = int'(clamp16(x0 + int'($urandom_range(1, 2000))));
      y1 = int'(clamp16(y0 + int'($urandom_range(1, 2000))));
      add_vertex(x0, y0);
      add_vertex(x1, y0);
      add_vertex(x1, y1);
      add_vertex(x0, y1);
      cx  = (x0 + x1) / 2;
      cy  = (y0 + y1) / 2;
      rad = (x1 - x0 > y1 - y0) ? x1 - x0 : y1 - y0;
    end else begin
      for (k = 0; k < n; k++) add_vertex(near(cx, rad), near(cy, rad));
    end
    tests = $urandom_range(4, 24);
    for (k = 0; k < tests; k++) begin
      probe(cx, cy, rad);
      if ($urandom_range(0, 29) == 0) push_item(CMD_UNUSED, any16(), any16());
    end
  endtask

  task automatic noise_round();
    int k, cnt;
    logic [CMD_W-1:0] cmd;
    cnt = $urandom_range(1, 6);
    for (k = 0; k < cnt; k++) begin
      cmd = CMD_W'($urandom_range(0, 3));
      if (cmd == CMD_CLEAR) begin
        shape_x.delete();
        shape_y.delete();
      end
      push_item(cmd, any16(), any16());
    end
  endtask

  initial begin : stimulus
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // empty table, then one and two vertices: all answer outside
    push_item(CMD_TEST, 16'sd0, 16'sd0);
    push_item(CMD_UNUSED, -16'sd1, -16'sd1);
    push_item(CMD_APPEND, 16'sh8000, 16'sh8000);
    push_item(CMD_TEST, 16'sd0, 16'sd0);
    push_item(CMD_APPEND, 16'sh7fff, 16'sh8000);
    push_item(CMD_TEST, 16'sd0, 16'sd0);
    // full-range triangle and square
    push_item(CMD_APPEND, 16'sh7fff, 16'sh7fff);
    push_item(CMD_TEST, 16'sd16384, -16'sd16384);
    push_item(CMD_APPEND, 16'sh8000, 16'sh7fff);
    push_item(CMD_TEST, 16'sd0, 16'sd0);
    push_item(CMD_TEST, 16'sh8000, 16'sh8000);
    push_item(CMD_TEST, 16'sh7fff, 16'sh7fff);
    push_item(CMD_TEST, 16'sh8000, 16'sd0);
    push_item(CMD_TEST, 16'sh7fff, 16'sd0);
    push_item(CMD_TEST, 16'sd0, 16'sh8000);
    push_item(CMD_UNUSED, 16'sh7fff, 16'sh7fff);
    push_item(CMD_TEST, 16'sd0, 16'sh7fff);
    push_item(CMD_CLEAR, 16'sd0, 16'sd0);
    push_item(CMD_TEST, 16'sd0, 16'sd0);
    // small slanted triangle, points exactly on slanted crossings
    push_item(CMD_APPEND, 16'sd0, 16'sd0);
    push_item(CMD_APPEND, 16'sd16, 16'sd32);
    push_item(CMD_APPEND, 16'sd32, 16'sd0);
    push_item(CMD_TEST, 16'sd16, 16'sd16);
    push_item(CMD_TEST, 16'sd8, 16'sd16);
    push_item(CMD_TEST, 16'sd24, 16'sd16);

    // fill the table and push appends past capacity
    polygon_round(MAX_VERTICES_DEF + 2);
    while (n_items < TARGET_ITEMS) begin
      if ($urandom_range(0, 6) == 0) noise_round();
      else polygon_round(0);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (ROW_DEPTH + 8) @(negedge clk);

    $display("run covered %0d items: %0d clears, %0d appends, %0d tests, %0d unused commands",
             n_items, n_clear, n_append, n_test, n_unused);
    $display("%0d appends refused on a full table, %0d points classified inside",
             refused_seen, inside_seen);
    if (errors == 0) begin
      $display("** point_in_polygon_classifier: PASSED **");
    end else begin
      $display("** point_in_polygon_classifier: FAILED **");
    end
    $finish;
  end

endmodule
